/* hdl/format_directive_parser_assert.svh */
// Assertion macros shared by the checker of the format directive parser.
// Depends on a clk and a rst signal in the scope that uses them.
`ifndef FORMAT_DIRECTIVE_PARSER_ASSERT_SVH
`define FORMAT_DIRECTIVE_PARSER_ASSERT_SVH

// same-cycle implication, disabled during reset
`define FDP_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define FDP_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/fdp_pkg.sv */
// Package of the format directive parser: character codes, conversion and
// size codes, token and phase types. No dependencies.
package fdp_pkg;

  localparam int NUMBER_BITS_DEF = 16;
  localparam int LENGTH_BITS_DEF = 8;
  localparam int QUEUE_DEPTH     = 4;

  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_ONE   = 8'h31;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_PCT   = 8'h25;
  localparam logic [7:0] CH_H     = 8'h68;
  localparam logic [7:0] CH_L     = 8'h6C;
  localparam logic [7:0] CH_BIG_L = 8'h4C;
  localparam logic [7:0] CH_C     = 8'h63;
  localparam logic [7:0] CH_S     = 8'h73;
  localparam logic [7:0] CH_P     = 8'h70;
  localparam logic [7:0] CH_D     = 8'h64;
  localparam logic [7:0] CH_I     = 8'h69;
  localparam logic [7:0] CH_O     = 8'h6F;
  localparam logic [7:0] CH_U     = 8'h75;
  localparam logic [7:0] CH_X     = 8'h78;
  localparam logic [7:0] CH_BIG_X = 8'h58;
  localparam logic [7:0] CH_F     = 8'h66;

  localparam logic [3:0] CONV_INVALID = 4'd0;
  localparam logic [3:0] CONV_C       = 4'd1;
  localparam logic [3:0] CONV_S       = 4'd2;
  localparam logic [3:0] CONV_P       = 4'd3;
  localparam logic [3:0] CONV_D       = 4'd4;
  localparam logic [3:0] CONV_I       = 4'd5;
  localparam logic [3:0] CONV_O       = 4'd6;
  localparam logic [3:0] CONV_U       = 4'd7;
  localparam logic [3:0] CONV_X       = 4'd8;
  localparam logic [3:0] CONV_BIG_X   = 4'd9;
  localparam logic [3:0] CONV_F       = 4'd10;
  localparam logic [3:0] CONV_PCT     = 4'd11;

  localparam logic [2:0] SIZE_NONE  = 3'd0;
  localparam logic [2:0] SIZE_HH    = 3'd1;
  localparam logic [2:0] SIZE_H     = 3'd2;
  localparam logic [2:0] SIZE_L     = 3'd3;
  localparam logic [2:0] SIZE_LL    = 3'd4;
  localparam logic [2:0] SIZE_BIG_L = 3'd5;

  typedef enum logic [3:0] {
    CL_OTHER, CL_HASH, CL_ZERO, CL_MINUS, CL_SPACE, CL_PLUS,
    CL_DIGIT, CL_DOT, CL_H, CL_L, CL_BIG_L, CL_PCT
  } cls_t;

  typedef struct packed {
    cls_t       cls;
    logic [3:0] digit;
    logic [3:0] conv;
  } tok_t;

  typedef enum logic [2:0] {
    PH_IDLE, PH_FLAGS, PH_WIDTH, PH_PREC, PH_AFTER_H, PH_AFTER_L, PH_CONV
  } phase_t;

  typedef enum logic [3:0] {
    ACT_IGNORE, ACT_OPEN, ACT_FLAG, ACT_WDIGIT, ACT_DOT, ACT_PDIGIT,
    ACT_SIZE_H, ACT_SIZE_L, ACT_SIZE_BIG_L, ACT_SIZE_HH, ACT_SIZE_LL, ACT_EMIT
  } act_t;

endpackage

/* hdl/format_directive_parser.sv */
// Format directive parser: characters in, one record per directive out.
// A record reaches m_tdata through the front register, token queue and output register.
// Throughput: one character per cycle while m_tready does not stall the output register.
// Reset: synchronous, active high; empties the front stage, queue and output register.
// Top level; depends on fdp_pkg, fdp_front, fdp_queue and fdp_back.
module format_directive_parser import fdp_pkg::*; #(
  parameter  int NUMBER_BITS = NUMBER_BITS_DEF,
  parameter  int LENGTH_BITS = LENGTH_BITS_DEF,
  localparam int DataBits    = ((10 + 2 * NUMBER_BITS + LENGTH_BITS + 7) / 8) * 8
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [7:0]          s_tdata,   // character
  output logic                m_tvalid,
  input  logic                m_tready,
  // alternate_flag, zero_pad_flag, left_align_flag, space_flag, plus_flag,
  // has_width, field_width, has_precision, precision_value, size_code,
  // consumed_length, zero fill
  output logic [DataBits-1:0] m_tdata,
  output logic [3:0]          m_tuser    // conversion
);

  logic f_valid;
  logic f_ready;
  tok_t f_tok;
  logic q_valid;
  logic q_ready;
  tok_t q_tok;

  fdp_front u_front (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .tok_valid (f_valid),
    .tok_ready (f_ready),
    .tok       (f_tok)
  );

  fdp_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (f_valid),
    .in_ready  (f_ready),
    .in_tok    (f_tok),
    .out_valid (q_valid),
    .out_ready (q_ready),
    .out_tok   (q_tok)
  );

  fdp_back #(
    .NUMBER_BITS (NUMBER_BITS),
    .LENGTH_BITS (LENGTH_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .tok_valid (q_valid),
    .tok_ready (q_ready),
    .tok       (q_tok),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

endmodule

/* hdl/fdp_front.sv */
// Front stage: registers each incoming character as a classified token.
// Depends on fdp_pkg.
module fdp_front import fdp_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] character
  output logic       tok_valid,
  input  logic       tok_ready,
  output tok_t       tok
);

  tok_t tok_c;

  always_comb begin
    tok_c.digit = s_tdata[3:0];
    tok_c.cls   = CL_OTHER;
    if (s_tdata >= CH_ONE && s_tdata <= CH_NINE) begin
      tok_c.cls = CL_DIGIT;
    end else begin
      unique case (s_tdata)
        CH_HASH:  tok_c.cls = CL_HASH;
        CH_ZERO:  tok_c.cls = CL_ZERO;
        CH_MINUS: tok_c.cls = CL_MINUS;
        CH_SPACE: tok_c.cls = CL_SPACE;
        CH_PLUS:  tok_c.cls = CL_PLUS;
        CH_DOT:   tok_c.cls = CL_DOT;
        CH_H:     tok_c.cls = CL_H;
        CH_L:     tok_c.cls = CL_L;
        CH_BIG_L: tok_c.cls = CL_BIG_L;
        CH_PCT:   tok_c.cls = CL_PCT;
        default:  tok_c.cls = CL_OTHER;
      endcase
    end
    unique case (s_tdata)
      CH_C:     tok_c.conv = CONV_C;
      CH_S:     tok_c.conv = CONV_S;
      CH_P:     tok_c.conv = CONV_P;
      CH_D:     tok_c.conv = CONV_D;
      CH_I:     tok_c.conv = CONV_I;
      CH_O:     tok_c.conv = CONV_O;
      CH_U:     tok_c.conv = CONV_U;
      CH_X:     tok_c.conv = CONV_X;
      CH_BIG_X: tok_c.conv = CONV_BIG_X;
      CH_F:     tok_c.conv = CONV_F;
      CH_PCT:   tok_c.conv = CONV_PCT;
      default:  tok_c.conv = CONV_INVALID;
    endcase
  end

  assign s_tready = !tok_valid || tok_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_valid <= 1'b0;
    end else if (s_tready) begin
      tok_valid <= s_tvalid;
    end
    if (s_tvalid && s_tready) begin
      tok <= tok_c;
    end
  end

endmodule

/* hdl/fdp_queue.sv */
// Short token queue between the front stage and the parser back end.
// Depends on fdp_pkg.
module fdp_queue import fdp_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  tok_t in_tok,
  output logic out_valid,
  input  logic out_ready,
  output tok_t out_tok
);

  localparam int PtrBits = $clog2(QUEUE_DEPTH);

  tok_t               mem [QUEUE_DEPTH];
  logic [PtrBits-1:0] wr_ptr;
  logic [PtrBits-1:0] rd_ptr;
  logic [PtrBits:0]   count;
  logic               push;
  logic               pop;

  assign in_ready  = count != (PtrBits+1)'(QUEUE_DEPTH);
  assign out_valid = count != '0;
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;
  assign out_tok   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PtrBits'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PtrBits'(1);
      end
      if (push && !pop) begin
        count <= count + (PtrBits+1)'(1);
      end else if (pop && !push) begin
        count <= count - (PtrBits+1)'(1);
      end
    end
    if (push) begin
      mem[wr_ptr] <= in_tok;
    end
  end

endmodule

/* hdl/fdp_back.sv */
// Parser back end: directive state machine, accumulators and output register.
// Depends on fdp_pkg.
module fdp_back import fdp_pkg::*; #(
  parameter  int NUMBER_BITS = NUMBER_BITS_DEF,
  parameter  int LENGTH_BITS = LENGTH_BITS_DEF,
  localparam int DataBits    = ((10 + 2 * NUMBER_BITS + LENGTH_BITS + 7) / 8) * 8
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                tok_valid,
  output logic                tok_ready,
  input  tok_t                tok,
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [DataBits-1:0] m_tdata,
  output logic [3:0]          m_tuser
);

  localparam int RecBits = 10 + 2 * NUMBER_BITS + LENGTH_BITS;
  localparam int MacBits = NUMBER_BITS + 4;

  phase_t                 phase, phase_next;
  act_t                   act;
  logic [4:0]             flags, flags_next;
  logic [NUMBER_BITS-1:0] wacc, wacc_next;
  logic [NUMBER_BITS-1:0] pacc, pacc_next;
  logic                   has_w, has_w_next;
  logic                   has_p, has_p_next;
  logic [2:0]             size, size_next;
  logic [LENGTH_BITS-1:0] count, count_next;
  logic [LENGTH_BITS-1:0] count_inc;
  logic [LENGTH_BITS-1:0] count_out;
  logic [NUMBER_BITS-1:0] mac_base;
  logic [MacBits-1:0]     mac_sum;
  logic [NUMBER_BITS-1:0] mac_sat;
  logic [2:0]             size_raw;
  logic [2:0]             size_out;
  logic [RecBits-1:0]     rec;
  logic                   take;
  logic                   is_digit;
  logic                   is_flag;
  act_t                   size_act;

  assign tok_ready = !m_tvalid || m_tready;
  assign take      = tok_valid && tok_ready;

  always_comb begin
    is_digit = tok.cls == CL_DIGIT || tok.cls == CL_ZERO;
    is_flag  = tok.cls == CL_HASH || tok.cls == CL_ZERO || tok.cls == CL_MINUS ||
               tok.cls == CL_SPACE || tok.cls == CL_PLUS;
    priority if (tok.cls == CL_H) begin
      size_act = ACT_SIZE_H;
    end else if (tok.cls == CL_L) begin
      size_act = ACT_SIZE_L;
    end else if (tok.cls == CL_BIG_L) begin
      size_act = ACT_SIZE_BIG_L;
    end else begin
      size_act = ACT_EMIT;
    end
    unique case (phase)
      PH_IDLE:    act = (tok.cls == CL_PCT) ? ACT_OPEN : ACT_IGNORE;
      PH_FLAGS: begin
        priority if (is_flag) act = ACT_FLAG;
        else if (tok.cls == CL_DIGIT) act = ACT_WDIGIT;
        else if (tok.cls == CL_DOT) act = ACT_DOT;
        else act = size_act;
      end
      PH_WIDTH: begin
        priority if (is_digit) act = ACT_WDIGIT;
        else if (tok.cls == CL_DOT) act = ACT_DOT;
        else act = size_act;
      end
      PH_PREC:    act = is_digit ? ACT_PDIGIT : size_act;
      PH_AFTER_H: act = (tok.cls == CL_H) ? ACT_SIZE_HH : ACT_EMIT;
      PH_AFTER_L: act = (tok.cls == CL_L) ? ACT_SIZE_LL : ACT_EMIT;
      PH_CONV:    act = ACT_EMIT;
      default:    act = ACT_IGNORE;
    endcase
    phase_next = phase;
    if (take) begin
      unique case (act)
        ACT_IGNORE:     phase_next = PH_IDLE;
        ACT_OPEN:       phase_next = PH_FLAGS;
        ACT_FLAG:       phase_next = PH_FLAGS;
        ACT_WDIGIT:     phase_next = PH_WIDTH;
        ACT_DOT:        phase_next = PH_PREC;
        ACT_PDIGIT:     phase_next = PH_PREC;
        ACT_SIZE_H:     phase_next = PH_AFTER_H;
        ACT_SIZE_L:     phase_next = PH_AFTER_L;
        ACT_SIZE_BIG_L: phase_next = PH_CONV;
        ACT_SIZE_HH:    phase_next = PH_CONV;
        ACT_SIZE_LL:    phase_next = PH_CONV;
        ACT_EMIT:       phase_next = PH_IDLE;
        default:        phase_next = PH_IDLE;
      endcase
    end
  end

  always_comb begin
    mac_base  = (act == ACT_PDIGIT) ? pacc : wacc;
    mac_sum   = MacBits'({mac_base, 3'b000}) + MacBits'({mac_base, 1'b0}) +
                MacBits'(tok.digit);
    mac_sat   = (mac_sum[MacBits-1:NUMBER_BITS] != '0) ? '1 : mac_sum[NUMBER_BITS-1:0];
    count_inc = (&count) ? count : count + LENGTH_BITS'(1);

    priority if (phase == PH_AFTER_H) size_raw = SIZE_H;
    else if (phase == PH_AFTER_L) size_raw = SIZE_L;
    else size_raw = size;
    size_out = size_raw;
    if (tok.conv == CONV_C || tok.conv == CONV_S || tok.conv == CONV_P) begin
      size_out = SIZE_NONE;
    end
    if (tok.conv != CONV_F && size_raw == SIZE_BIG_L) begin
      size_out = SIZE_NONE;
    end
    if (tok.conv == CONV_F &&
        (size_raw == SIZE_HH || size_raw == SIZE_H || size_raw == SIZE_LL)) begin
      size_out = SIZE_NONE;
    end
    count_out = (tok.conv != CONV_INVALID) ? count_inc : count;
    rec = {count_out, size_out, pacc, has_p, wacc, has_w, flags};

    flags_next = flags;
    wacc_next  = wacc;
    pacc_next  = pacc;
    has_w_next = has_w;
    has_p_next = has_p;
    size_next  = size;
    count_next = count;
    if (take) begin
      unique case (act)
        ACT_IGNORE: ;
        ACT_OPEN, ACT_EMIT: begin
          flags_next = '0;
          wacc_next  = '0;
          pacc_next  = '0;
          has_w_next = 1'b0;
          has_p_next = 1'b0;
          size_next  = SIZE_NONE;
          count_next = (act == ACT_OPEN) ? LENGTH_BITS'(1) : '0;
        end
        ACT_FLAG: begin
          flags_next[0] = flags[0] | (tok.cls == CL_HASH);
          flags_next[1] = flags[1] | (tok.cls == CL_ZERO);
          flags_next[2] = flags[2] | (tok.cls == CL_MINUS);
          flags_next[3] = flags[3] | (tok.cls == CL_SPACE);
          flags_next[4] = flags[4] | (tok.cls == CL_PLUS);
          count_next    = count_inc;
        end
        ACT_WDIGIT: begin
          wacc_next  = mac_sat;
          has_w_next = 1'b1;
          count_next = count_inc;
        end
        ACT_DOT: begin
          has_p_next = 1'b1;
          count_next = count_inc;
        end
        ACT_PDIGIT: begin
          pacc_next  = mac_sat;
          count_next = count_inc;
        end
        ACT_SIZE_H, ACT_SIZE_L: count_next = count_inc;
        ACT_SIZE_BIG_L: begin
          size_next  = SIZE_BIG_L;
          count_next = count_inc;
        end
        ACT_SIZE_HH: begin
          size_next  = SIZE_HH;
          count_next = count_inc;
        end
        ACT_SIZE_LL: begin
          size_next  = SIZE_LL;
          count_next = count_inc;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= PH_IDLE;
      flags    <= '0;
      wacc     <= '0;
      pacc     <= '0;
      has_w    <= 1'b0;
      has_p    <= 1'b0;
      size     <= SIZE_NONE;
      count    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      phase <= phase_next;
      flags <= flags_next;
      wacc  <= wacc_next;
      pacc  <= pacc_next;
      has_w <= has_w_next;
      has_p <= has_p_next;
      size  <= size_next;
      count <= count_next;
      if (take && act == ACT_EMIT) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
    if (take && act == ACT_EMIT) begin
      m_tdata <= DataBits'(rec);
      m_tuser <= tok.conv;
    end
  end

endmodule

/* hdl/fdp_port_checker.sv */
// Port checker of the format directive parser, bound to the top level.
// Depends on fdp_pkg and format_directive_parser_assert.svh.
`include "format_directive_parser_assert.svh"

module fdp_port_checker import fdp_pkg::*; #(
  parameter  int NUMBER_BITS = NUMBER_BITS_DEF,
  parameter  int LENGTH_BITS = LENGTH_BITS_DEF,
  localparam int DataBits    = ((10 + 2 * NUMBER_BITS + LENGTH_BITS + 7) / 8) * 8
) (
  input logic                clk,
  input logic                rst,
  input logic                s_tready,
  input logic                m_tvalid,
  input logic                m_tready,
  input logic [DataBits-1:0] m_tdata,
  input logic [3:0]          m_tuser
);

  localparam int SizeLo = 2 * NUMBER_BITS + 7;
  localparam int LenLo  = 2 * NUMBER_BITS + 10;

  logic [2:0]             size_code;
  logic [LENGTH_BITS-1:0] consumed;
  logic                   stalled;
  logic                   rec_ok;
  logic                   conv_csp;
  logic                   conv_not_f;

  assign size_code  = m_tdata[SizeLo +: 3];
  assign consumed   = m_tdata[LenLo +: LENGTH_BITS];
  assign stalled    = m_tvalid && !m_tready;
  assign rec_ok     = m_tuser <= CONV_PCT && consumed != '0;
  assign conv_csp   = m_tvalid && (m_tuser == CONV_C || m_tuser == CONV_S || m_tuser == CONV_P);
  assign conv_not_f = m_tvalid && m_tuser != CONV_F;

  `FDP_ASSERT_NXT(a_hold, stalled, m_tvalid && $stable({m_tuser, m_tdata}), "stalled record changed")
  `FDP_ASSERT_IMP(a_record, m_tvalid, rec_ok, "bad conversion code or zero length")
  `FDP_ASSERT_IMP(a_size_csp, conv_csp, size_code == SIZE_NONE, "size kept for c, s or p")
  `FDP_ASSERT_IMP(a_size_big_l, conv_not_f, size_code != SIZE_BIG_L, "L kept without f")
  `FDP_ASSERT_IMP(a_reset, $past(rst), s_tready && !m_tvalid, "not empty after reset")

endmodule

bind format_directive_parser fdp_port_checker #(
  .NUMBER_BITS (NUMBER_BITS),
  .LENGTH_BITS (LENGTH_BITS)
) u_port_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

/* verif/tb_format_directive_parser.sv */
// Testbench for format_directive_parser: streams format text one character per
// transaction and checks each directive record against an in-bench parser.
// Depends on fdp_pkg and the format_directive_parser RTL.
`timescale 1ns / 100ps

module tb_format_directive_parser;
  import fdp_pkg::*;

  typedef struct packed {
    logic [5:0]  fill;
    logic [7:0]  consumed;
    logic [2:0]  size;
    logic [15:0] prec;
    logic        has_prec;
    logic [15:0] width;
    logic        has_width;
    logic        plus;
    logic        space;
    logic        left;
    logic        zero;
    logic        alt;
  } dir_rec_t;

  typedef struct packed {
    logic [3:0] conv;
    dir_rec_t   rec;
  } dir_exp_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'h00;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [55:0] m_tdata;
  logic [3:0]  m_tuser;

  format_directive_parser dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  dir_exp_t   dir_expected[$];
  int         fail_count = 0;
  int         chars_sent = 0;
  int         records_checked = 0;
  int         invalid_seen = 0;
  bit         no_gaps = 1'b0;
  int         stall_left = 0;

  phase_t      ph = PH_IDLE;
  logic [4:0]  flag_q = '0;
  logic [15:0] width_q = '0;
  logic [15:0] prec_q = '0;
  logic        has_w_q = 1'b0;
  logic        has_p_q = 1'b0;
  logic [2:0]  size_q = SIZE_NONE;
  logic [7:0]  len_q = '0;

  localparam logic [7:0] FLAG_CHARS[5] = '{CH_HASH, CH_ZERO, CH_MINUS, CH_SPACE, CH_PLUS};
  localparam logic [7:0] CONV_CHARS[11] = '{CH_C, CH_S, CH_P, CH_D, CH_I, CH_O, CH_U,
                                            CH_X, CH_BIG_X, CH_F, CH_PCT};

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [15:0] add_digit(logic [15:0] acc, logic [7:0] c);
    int unsigned v;
    v = 32'(acc) * 10 + 32'(c - CH_ZERO);
    return (v > 32'hFFFF) ? 16'hFFFF : v[15:0];
  endfunction

  function automatic logic [3:0] conv_of(logic [7:0] c);
    case (c)
      CH_C:     return CONV_C;
      CH_S:     return CONV_S;
      CH_P:     return CONV_P;
      CH_D:     return CONV_D;
      CH_I:     return CONV_I;
      CH_O:     return CONV_O;
      CH_U:     return CONV_U;
      CH_X:     return CONV_X;
      CH_BIG_X: return CONV_BIG_X;
      CH_F:     return CONV_F;
      CH_PCT:   return CONV_PCT;
      default:  return CONV_INVALID;
    endcase
  endfunction

  function automatic string fmt_rec(dir_exp_t e);
    return $sformatf("conv=%0d flags=%b w=%0d/%0d p=%0d/%0d size=%0d len=%0d fill=%h",
                     e.conv, {e.rec.plus, e.rec.space, e.rec.left, e.rec.zero, e.rec.alt},
                     e.rec.has_width, e.rec.width, e.rec.has_prec, e.rec.prec,
                     e.rec.size, e.rec.consumed, e.rec.fill);
  endfunction

  task automatic note_failure(string msg);
    fail_count++;
    if (fail_count <= 10) $display("%s", msg);
  endtask

  task automatic clear_dir_state();
    flag_q  = '0;
    width_q = '0;
    prec_q  = '0;
    has_w_q = 1'b0;
    has_p_q = 1'b0;
    size_q  = SIZE_NONE;
    len_q   = '0;
  endtask

  task automatic open_dir();
    clear_dir_state();
    len_q = 8'd1;
    ph = PH_FLAGS;
  endtask

  task automatic bump_len();
    if (len_q != 8'hFF) len_q++;
  endtask

  task automatic emit_record(logic [3:0] conv);
    dir_exp_t   e;
    logic [2:0] sz;
    sz = size_q;
    if (conv == CONV_C || conv == CONV_S || conv == CONV_P) sz = SIZE_NONE;
    if (conv != CONV_F && sz == SIZE_BIG_L) sz = SIZE_NONE;
    if (conv == CONV_F && (sz == SIZE_HH || sz == SIZE_H || sz == SIZE_LL)) sz = SIZE_NONE;
    e.conv          = conv;
    e.rec.fill      = '0;
    e.rec.consumed  = len_q;
    e.rec.size      = sz;
    e.rec.prec      = prec_q;
    e.rec.has_prec  = has_p_q;
    e.rec.width     = width_q;
    e.rec.has_width = has_w_q;
    e.rec.plus      = flag_q[4];
    e.rec.space     = flag_q[3];
    e.rec.left      = flag_q[2];
    e.rec.zero      = flag_q[1];
    e.rec.alt       = flag_q[0];
    dir_expected.push_back(e);
    clear_dir_state();
    ph = PH_IDLE;
  endtask

  task automatic end_with_conv(logic [7:0] c);
    logic [3:0] code;
    code = conv_of(c);
    if (code != CONV_INVALID) begin
      bump_len();
      emit_record(code);
    end else begin
      emit_record(CONV_INVALID);
      if (c == CH_PCT) open_dir();
    end
  endtask

  task automatic size_or_conv(logic [7:0] c);
    if (c == CH_H) begin
      bump_len();
      ph = PH_AFTER_H;
    end else if (c == CH_L) begin
      bump_len();
      ph = PH_AFTER_L;
    end else if (c == CH_BIG_L) begin
      bump_len();
      size_q = SIZE_BIG_L;
      ph = PH_CONV;
    end else begin
      end_with_conv(c);
    end
  endtask

  task automatic advance_parser(logic [7:0] c);
    logic is_digit;
    is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
    case (ph)
      PH_FLAGS: begin
        if (c == CH_HASH) begin
          flag_q[0] = 1'b1;
          bump_len();
        end else if (c == CH_ZERO) begin
          flag_q[1] = 1'b1;
          bump_len();
        end else if (c == CH_MINUS) begin
          flag_q[2] = 1'b1;
          bump_len();
        end else if (c == CH_SPACE) begin
          flag_q[3] = 1'b1;
          bump_len();
        end else if (c == CH_PLUS) begin
          flag_q[4] = 1'b1;
          bump_len();
        end else if (is_digit) begin
          has_w_q = 1'b1;
          width_q = add_digit(width_q, c);
          bump_len();
          ph = PH_WIDTH;
        end else if (c == CH_DOT) begin
          has_p_q = 1'b1;
          bump_len();
          ph = PH_PREC;
        end else begin
          size_or_conv(c);
        end
      end
      PH_WIDTH: begin
        if (is_digit) begin
          width_q = add_digit(width_q, c);
          bump_len();
        end else if (c == CH_DOT) begin
          has_p_q = 1'b1;
          bump_len();
          ph = PH_PREC;
        end else begin
          size_or_conv(c);
        end
      end
      PH_PREC: begin
        if (is_digit) begin
          prec_q = add_digit(prec_q, c);
          bump_len();
        end else begin
          size_or_conv(c);
        end
      end
      PH_AFTER_H: begin
        if (c == CH_H) begin
          size_q = SIZE_HH;
          bump_len();
          ph = PH_CONV;
        end else begin
          size_q = SIZE_H;
          end_with_conv(c);
        end
      end
      PH_AFTER_L: begin
        if (c == CH_L) begin
          size_q = SIZE_LL;
          bump_len();
          ph = PH_CONV;
        end else begin
          size_q = SIZE_L;
          end_with_conv(c);
        end
      end
      PH_CONV: begin
        end_with_conv(c);
      end
      default: begin
        ph = PH_IDLE;
        if (c == CH_PCT) open_dir();
      end
    endcase
  endtask

  task automatic send_char(logic [7:0] c);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= c;
    do @(posedge clk); while (!s_tready);
    chars_sent++;
    advance_parser(c);
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i]);
  endtask

  task automatic send_random_directive();
    logic [7:0] txt[$];
    int         nd;
    int         pos;
    txt.push_back(CH_PCT);
    repeat ($urandom_range(0, 3)) txt.push_back(FLAG_CHARS[$urandom_range(0, 4)]);
    if ($urandom_range(0, 1) == 1) begin
      nd = ($urandom_range(0, 15) == 0) ? $urandom_range(5, 7) : $urandom_range(1, 3);
      txt.push_back(CH_ONE + 8'($urandom_range(0, 8)));
      repeat (nd - 1) txt.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
    end
    if ($urandom_range(0, 2) == 0) begin
      txt.push_back(CH_DOT);
      nd = ($urandom_range(0, 15) == 0) ? $urandom_range(5, 7) : $urandom_range(0, 3);
      repeat (nd) txt.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
    end
    case ($urandom_range(0, 7))
      0: txt.push_back(CH_H);
      1: begin
        txt.push_back(CH_H);
        txt.push_back(CH_H);
      end
      2: txt.push_back(CH_L);
      3: begin
        txt.push_back(CH_L);
        txt.push_back(CH_L);
      end
      4: txt.push_back(CH_BIG_L);
      default: ;
    endcase
    txt.push_back(CONV_CHARS[$urandom_range(0, 10)]);
    if ($urandom_range(0, 9) == 0) begin
      pos = $urandom_range(1, txt.size() - 1);
      txt[pos] = 8'($urandom_range(0, 255));
    end
    if ($urandom_range(0, 19) == 0) void'(txt.pop_back());
    foreach (txt[i]) send_char(txt[i]);
  endtask

  task automatic test_directed_cases();
    send_text("%#0- +12.5hhd");
    send_text("%0100.x");
    send_text("%.+");
    send_text("%Lf%Ls");
    send_text("%hq%lu");
    send_text("%99999999.123456u");
    send_text("%%%");
    send_char(8'h00);
    send_char(8'hFF);
  endtask

  task automatic test_random_directives(int n_chars);
    int stop_at;
    stop_at = chars_sent + n_chars;
    while (chars_sent < stop_at) begin
      if ($urandom_range(0, 4) == 0) begin
        repeat ($urandom_range(1, 4)) send_char(8'($urandom_range(0, 255)));
      end else begin
        send_random_directive();
      end
    end
  endtask

  task automatic test_back_to_back(int n_chars);
    no_gaps = 1'b1;
    test_random_directives(n_chars);
    no_gaps = 1'b0;
  endtask

  task automatic test_long_directive();
    send_char(CH_PCT);
    repeat (280) send_char(FLAG_CHARS[$urandom_range(0, 4)]);
    send_text("70000.70000llx");
  endtask

  always @(posedge clk) begin
    if (no_gaps) begin
      m_tready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
      if ($urandom_range(0, 3) == 0) stall_left = pick_gap();
    end
  end

  always @(posedge clk) begin : result_check
    dir_exp_t got;
    dir_exp_t want;
    if (!rst && m_tvalid && m_tready) begin
      got = {m_tuser, m_tdata};
      if (dir_expected.size() == 0) begin
        note_failure($sformatf("unexpected record: %s", fmt_rec(got)));
      end else begin
        want = dir_expected.pop_front();
        records_checked++;
        if (want.conv == CONV_INVALID) invalid_seen++;
        if (got !== want)
          note_failure($sformatf("record %0d mismatch\n  expected %s\n  actual   %s",
                                 records_checked, fmt_rec(want), fmt_rec(got)));
      end
    end
  end

  initial begin
    #(8_000_000);
    $display("tb_format_directive_parser NOT OK");
    $finish;
  end

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed_cases();
    test_random_directives(800);
    test_back_to_back(200);
    test_long_directive();
    test_random_directives(300);
    s_tvalid <= 1'b0;
    while (dir_expected.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    $display("Sent %0d characters; checked %0d directive records, %0d of them invalid.",
             chars_sent, records_checked, invalid_seen);
    if (fail_count == 0) begin
      $display("tb_format_directive_parser OK");
    end else begin
      $display("%0d failures", fail_count);
      $display("tb_format_directive_parser NOT OK");
    end
    $finish;
  end

endmodule
